// ----- rtl/otst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otst_pkg
// Shared widths, opcodes and status codes of the one-shot timer table.
// ----------------------------------------------------------------------------
package otst_pkg;

    localparam int OP_W     = 2;
    localparam int HANDLE_W = 5;
    localparam int PERIOD_W = 31;
    localparam int QUEUE_W  = 16;
    localparam int EVENT_W  = 32;
    localparam int STATUS_W = 2;
    localparam int STEP_W   = 10;

    localparam logic [STEP_W-1:0] STEP_RESET = 10'd10;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;
    localparam logic [OP_W-1:0] OP_RESET  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_TIMER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

endpackage

// ----- rtl/otst_free_find.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otst_free_find
// Priority encoder that picks the lowest slot whose live bit is clear.
// ----------------------------------------------------------------------------
module otst_free_find #(
    parameter int NUM_TIMERS = 16,
    parameter int IDX_W      = 4
) (
    input  logic [NUM_TIMERS-1:0] live,
    output logic                  found,
    output logic [IDX_W-1:0]      idx
);

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!live[i])
            begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
    end

endmodule

// ----- rtl/one_shot_timer_table_core.sv -----
`timescale 1ns / 1ps
// Response: set, cancel and reset answer in the cycle after the transaction.
// Tick: scans one slot per cycle through the remaining-time memory, pausing while an expiry
//   waits on a stalled output; the last result is posted once the scan is finished.
// Throughput: one command per cycle between ticks while the output is free; none is taken during a tick.
// Reset: all slots free, tick step 10, no results pending; memories keep contents.
// ----------------------------------------------------------------------------
// one_shot_timer_table_core
// Table of one-shot timers held in synchronous memories, scanned on each tick.
// ----------------------------------------------------------------------------
module one_shot_timer_table_core #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [otst_pkg::STEP_W-1:0]       cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [otst_pkg::OP_W-1:0]         op,
    input  logic [otst_pkg::HANDLE_W-1:0]     handle,
    input  logic [otst_pkg::PERIOD_W-1:0]     period_ms,
    input  logic [otst_pkg::QUEUE_W-1:0]      queue_id,
    input  logic [otst_pkg::EVENT_W-1:0]      event_code,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [otst_pkg::STATUS_W-1:0]     status,
    output logic [otst_pkg::HANDLE_W-1:0]     new_handle,
    output logic                              fired,
    output logic [otst_pkg::HANDLE_W-1:0]     fired_handle,
    output logic [otst_pkg::QUEUE_W-1:0]      fired_queue,
    output logic [otst_pkg::EVENT_W-1:0]      fired_event,
    output logic                              last
);

    import otst_pkg::*;

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int INFO_W = QUEUE_W + EVENT_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

    state_t                  state_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [NUM_TIMERS-1:0]   live_reg;
    logic [NUM_TIMERS-1:0]   canc_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    pend_valid_reg;
    logic [HANDLE_W-1:0]     pend_handle_reg;
    logic [INFO_W-1:0]       pend_info_reg;

    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [HANDLE_W-1:0]     new_handle_reg;
    logic                    fired_reg;
    logic [HANDLE_W-1:0]     fired_handle_reg;
    logic [INFO_W-1:0]       fired_info_reg;
    logic                    last_reg;

    logic [PERIOD_W-1:0]     rem_mem [NUM_TIMERS];
    logic [INFO_W-1:0]       info_mem [NUM_TIMERS];
    logic [PERIOD_W-1:0]     rem_rd_reg;
    logic [INFO_W-1:0]       info_rd_reg;

    logic                    out_free;
    logic                    in_acc;
    logic                    free_found;
    logic [IDX_W-1:0]        free_idx;
    logic                    hdl_zero;
    logic                    hdl_range;
    logic [IDX_W-1:0]        hdl_idx;
    logic                    hdl_live;
    logic [STATUS_W-1:0]     cmd_status;
    logic                    cur_live;
    logic                    cur_canc;
    logic                    cur_fire;
    logic                    last_idx;
    logic                    scan_go;
    logic [HANDLE_W-1:0]     cur_handle;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    rem_we;
    logic [IDX_W-1:0]        rem_waddr;
    logic [PERIOD_W-1:0]     rem_wdata;
    logic                    info_we;
    logic                    push_en;
    logic [STATUS_W-1:0]     push_status;
    logic [HANDLE_W-1:0]     push_new_handle;
    logic                    push_fired;
    logic [HANDLE_W-1:0]     push_fired_handle;
    logic [INFO_W-1:0]       push_info;
    logic                    push_last;

    otst_free_find #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_free_find (
        .live  (live_reg),
        .found (free_found),
        .idx   (free_idx)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_acc   = in_valid && in_ready;

    assign hdl_zero  = (handle == '0);
    assign hdl_range = !hdl_zero && (32'(handle) <= 32'(NUM_TIMERS));
    assign hdl_idx   = IDX_W'(handle - HANDLE_W'(1));
    assign hdl_live  = hdl_range && live_reg[hdl_idx];

    always_comb
    begin
        case (op)
            OP_SET:  cmd_status = free_found ? ST_OK : ST_FULL;
            default: cmd_status = hdl_zero ? ST_NO_TIMER : (hdl_live ? ST_OK : ST_EXPIRED);
        endcase
    end

    assign cur_live   = live_reg[idx_reg];
    assign cur_canc   = canc_reg[idx_reg];
    assign cur_fire   = cur_live && !cur_canc && (rem_rd_reg <= PERIOD_W'(step_reg));
    assign last_idx   = (idx_reg == IDX_W'(NUM_TIMERS - 1));
    assign scan_go    = (state_reg == S_SCAN) && !(cur_fire && pend_valid_reg && !out_free);
    assign cur_handle = HANDLE_W'(idx_reg) + HANDLE_W'(1);

    assign rd_en   = (in_acc && (op == OP_TICK)) || (scan_go && !last_idx);
    assign rd_addr = (state_reg == S_SCAN) ? idx_reg + IDX_W'(1) : '0;

    always_comb
    begin
        rem_we    = 1'b0;
        rem_waddr = hdl_idx;
        rem_wdata = period_ms;
        if (state_reg == S_SCAN)
        begin
            rem_we    = scan_go && cur_live && !cur_canc && !cur_fire;
            rem_waddr = idx_reg;
            rem_wdata = rem_rd_reg - PERIOD_W'(step_reg);
        end
        else if (in_acc && (op == OP_SET))
        begin
            rem_we    = free_found;
            rem_waddr = free_idx;
        end
        else if (in_acc && (op == OP_RESET))
        begin
            rem_we = hdl_live;
        end
    end

    assign info_we = in_acc && (op == OP_SET) && free_found;

    always_comb
    begin
        push_en           = 1'b0;
        push_status       = ST_OK;
        push_new_handle   = '0;
        push_fired        = 1'b0;
        push_fired_handle = '0;
        push_info         = '0;
        push_last         = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                push_en     = in_acc && (op != OP_TICK);
                push_status = cmd_status;
                if ((op == OP_SET) && free_found)
                    push_new_handle = HANDLE_W'(free_idx) + HANDLE_W'(1);
            end
            S_SCAN:
            begin
                push_en           = scan_go && cur_fire && pend_valid_reg;
                push_fired        = 1'b1;
                push_fired_handle = pend_handle_reg;
                push_info         = pend_info_reg;
                push_last         = 1'b0;
            end
            S_FIN:
            begin
                push_en = out_free;
                if (pend_valid_reg)
                begin
                    push_fired        = 1'b1;
                    push_fired_handle = pend_handle_reg;
                    push_info         = pend_info_reg;
                end
            end
            default:
            begin
                push_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rem_we)
            rem_mem[rem_waddr] <= rem_wdata;
        if (info_we)
            info_mem[free_idx] <= {queue_id, event_code};
        if (rd_en)
        begin
            rem_rd_reg  <= rem_mem[rd_addr];
            info_rd_reg <= info_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            live_reg         <= '0;
            canc_reg         <= '0;
            step_reg         <= STEP_RESET;
            pend_valid_reg   <= 1'b0;
            pend_handle_reg  <= '0;
            pend_info_reg    <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= ST_OK;
            new_handle_reg   <= '0;
            fired_reg        <= 1'b0;
            fired_handle_reg <= '0;
            fired_info_reg   <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                step_reg <= cfg_wdata;

            if (push_en)
            begin
                out_valid_reg    <= 1'b1;
                status_reg       <= push_status;
                new_handle_reg   <= push_new_handle;
                fired_reg        <= push_fired;
                fired_handle_reg <= push_fired_handle;
                fired_info_reg   <= push_info;
                last_reg         <= push_last;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (op)
                            OP_TICK:
                            begin
                                state_reg <= S_SCAN;
                                idx_reg   <= '0;
                            end
                            OP_SET:
                            begin
                                if (free_found)
                                begin
                                    live_reg[free_idx] <= 1'b1;
                                    canc_reg[free_idx] <= 1'b0;
                                end
                            end
                            OP_CANCEL:
                            begin
                                if (hdl_live)
                                    canc_reg[hdl_idx] <= 1'b1;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (scan_go)
                    begin
                        if (cur_live && (cur_canc || cur_fire))
                        begin
                            live_reg[idx_reg] <= 1'b0;
                            canc_reg[idx_reg] <= 1'b0;
                        end
                        if (cur_fire)
                        begin
                            pend_valid_reg  <= 1'b1;
                            pend_handle_reg <= cur_handle;
                            pend_info_reg   <= info_rd_reg;
                        end
                        if (last_idx)
                            state_reg <= S_FIN;
                        else
                            idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign new_handle   = new_handle_reg;
    assign fired        = fired_reg;
    assign fired_handle = fired_handle_reg;
    assign fired_queue  = fired_info_reg[INFO_W-1:EVENT_W];
    assign fired_event  = fired_info_reg[EVENT_W-1:0];
    assign last         = last_reg;

endmodule

// ----- rtl/otst_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otst_checker
// Port-level checks of the one-shot timer table, bound to the top level.
// ----------------------------------------------------------------------------
module otst_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [otst_pkg::STATUS_W-1:0]     status,
    input logic [otst_pkg::HANDLE_W-1:0]     new_handle,
    input logic                              fired,
    input logic [otst_pkg::HANDLE_W-1:0]     fired_handle,
    input logic [otst_pkg::QUEUE_W-1:0]      fired_queue,
    input logic [otst_pkg::EVENT_W-1:0]      fired_event,
    input logic                              last
);

    import otst_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(fired)
            && $stable(fired_handle) && $stable(last))
        else $error("result changed while stalled");

    a_fired_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> status == ST_OK && new_handle == '0 && fired_handle != '0)
        else $error("expiry transaction with bad status or handle");

    a_plain_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> last && fired_handle == '0 && fired_queue == '0
            && fired_event == '0)
        else $error("non-expiry transaction not final or carries expiry data");

    a_full_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> new_handle == '0)
        else $error("failed transaction returned a handle");

endmodule

bind one_shot_timer_table_core otst_checker u_otst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .new_handle   (new_handle),
    .fired        (fired),
    .fired_handle (fired_handle),
    .fired_queue  (fired_queue),
    .fired_event  (fired_event),
    .last         (last)
);

// ----- verif/one_shot_timer_table_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_table_core_tb
// Drives set, cancel, reset and tick transactions into the timer table and
// predicts every response and expiry from a private copy of the table. The
// run opens with corner cases, then walks through several tick step values:
// random mixes, a full-table fill that fires every slot on one tick, and a
// final stretch with no idling on either side.
// ----------------------------------------------------------------------------
module one_shot_timer_table_core_tb;

    import otst_pkg::*;

    localparam int NT             = 16;
    localparam int SETTLE_CYCLES  = NT + 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] new_handle;
        logic                fired;
        logic [HANDLE_W-1:0] fired_handle;
        logic [QUEUE_W-1:0]  fired_queue;
        logic [EVENT_W-1:0]  fired_event;
        logic                last;
    } timer_result_t;

    class timer_expiry_board;
        bit                  armed[NT];
        bit                  killed[NT];
        longint              time_left[NT];
        logic [QUEUE_W-1:0]  dest_queue[NT];
        logic [EVENT_W-1:0]  event_tag[NT];
        logic [STEP_W-1:0]   step_ms;
        timer_result_t       due_results[$];
        int                  err_count;
        int                  result_count;

        function new();
            step_ms      = STEP_RESET;
            err_count    = 0;
            result_count = 0;
            for (int i = 0; i < NT; i++)
            begin
                armed[i]  = 1'b0;
                killed[i] = 1'b0;
            end
        endfunction

        function void push_reply(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] nh);
            timer_result_t r;
            r = '{st, nh, 1'b0, '0, '0, '0, 1'b1};
            due_results.push_back(r);
        endfunction

        function void log_command(logic [OP_W-1:0] c, logic [HANDLE_W-1:0] h,
                                  logic [PERIOD_W-1:0] p, logic [QUEUE_W-1:0] q,
                                  logic [EVENT_W-1:0] e);
            int            hit[$];
            int            slot;
            timer_result_t r;
            slot = -1;
            if (c == OP_TICK)
            begin
                for (int i = 0; i < NT; i++)
                begin
                    if (armed[i] && killed[i])
                    begin
                        armed[i]  = 1'b0;
                        killed[i] = 1'b0;
                    end
                end
                for (int i = 0; i < NT; i++)
                begin
                    if (armed[i])
                    begin
                        time_left[i] = time_left[i] - longint'(step_ms);
                        if (time_left[i] <= 0)
                        begin
                            hit.push_back(i);
                            armed[i]  = 1'b0;
                            killed[i] = 1'b0;
                        end
                    end
                end
                if (hit.size() == 0)
                    push_reply(ST_OK, '0);
                for (int k = 0; k < hit.size(); k++)
                begin
                    r.status       = ST_OK;
                    r.new_handle   = '0;
                    r.fired        = 1'b1;
                    r.fired_handle = HANDLE_W'(hit[k] + 1);
                    r.fired_queue  = dest_queue[hit[k]];
                    r.fired_event  = event_tag[hit[k]];
                    r.last         = (k == hit.size() - 1);
                    due_results.push_back(r);
                end
            end
            else if (c == OP_SET)
            begin
                for (int i = 0; i < NT; i++)
                begin
                    if (slot < 0 && !armed[i])
                        slot = i;
                end
                if (slot < 0)
                    push_reply(ST_FULL, '0);
                else
                begin
                    armed[slot]      = 1'b1;
                    killed[slot]     = 1'b0;
                    time_left[slot]  = longint'(p);
                    dest_queue[slot] = q;
                    event_tag[slot]  = e;
                    push_reply(ST_OK, HANDLE_W'(slot + 1));
                end
            end
            else if (h == 0)
                push_reply(ST_NO_TIMER, '0);
            else if (int'(h) > NT || !armed[int'(h) - 1])
                push_reply(ST_EXPIRED, '0);
            else
            begin
                if (c == OP_CANCEL)
                    killed[int'(h) - 1] = 1'b1;
                else
                    time_left[int'(h) - 1] = longint'(p);
                push_reply(ST_OK, '0);
            end
        endfunction

        task report_mismatch(string msg);
            err_count++;
            $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        task check_result(timer_result_t got);
            timer_result_t exp;
            string         bad;
            result_count++;
            if (due_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          result_count));
                return;
            end
            exp = due_results.pop_front();
            bad = "";
            if (got.status !== exp.status)             bad = {bad, " status"};
            if (got.new_handle !== exp.new_handle)     bad = {bad, " new_handle"};
            if (got.fired !== exp.fired)               bad = {bad, " fired"};
            if (got.fired_handle !== exp.fired_handle) bad = {bad, " fired_handle"};
            if (got.fired_queue !== exp.fired_queue)   bad = {bad, " fired_queue"};
            if (got.fired_event !== exp.fired_event)   bad = {bad, " fired_event"};
            if (got.last !== exp.last)                 bad = {bad, " last"};
            if (bad != "")
                report_mismatch($sformatf(
                    "result %0d [%s ] got %0d/%0d/%0d/%0d/%h/%h/%0d exp %0d/%0d/%0d/%0d/%h/%h/%0d",
                    result_count, bad, got.status, got.new_handle, got.fired,
                    got.fired_handle, got.fired_queue, got.fired_event, got.last,
                    exp.status, exp.new_handle, exp.fired, exp.fired_handle,
                    exp.fired_queue, exp.fired_event, exp.last));
        endtask
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_we     = 1'b0;
    logic [STEP_W-1:0]   cfg_wdata  = '0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     op         = '0;
    logic [HANDLE_W-1:0] handle     = '0;
    logic [PERIOD_W-1:0] period_ms  = '0;
    logic [QUEUE_W-1:0]  queue_id   = '0;
    logic [EVENT_W-1:0]  event_code = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] new_handle;
    logic                fired;
    logic [HANDLE_W-1:0] fired_handle;
    logic [QUEUE_W-1:0]  fired_queue;
    logic [EVENT_W-1:0]  fired_event;
    logic                last;

    bit                  calm = 1'b0;
    int                  ready_hold = 0;
    timer_result_t       seen;
    timer_expiry_board   sb = new();

    one_shot_timer_table_core #(
        .NUM_TIMERS(NT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .handle       (handle),
        .period_ms    (period_ms),
        .queue_id     (queue_id),
        .event_code   (event_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .new_handle   (new_handle),
        .fired        (fired),
        .fired_handle (fired_handle),
        .fired_queue  (fired_queue),
        .fired_event  (fired_event),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stall the result channel in bursts
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold = ready_hold - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            ready_hold = $urandom_range(0, 16);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.status       = status;
            seen.new_handle   = new_handle;
            seen.fired        = fired;
            seen.fired_handle = fired_handle;
            seen.fired_queue  = fired_queue;
            seen.fired_event  = fired_event;
            seen.last         = last;
            sb.check_result(seen);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** one_shot_timer_table_core: FAILED **");
        $finish;
    end

    task automatic issue_command(logic [OP_W-1:0] c, logic [HANDLE_W-1:0] h,
                                 logic [PERIOD_W-1:0] p, logic [QUEUE_W-1:0] q,
                                 logic [EVENT_W-1:0] e);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= c;
        handle     <= h;
        period_ms  <= p;
        queue_id   <= q;
        event_code <= e;
        do
            @(posedge clk);
        while (!in_ready);
        sb.log_command(c, h, p, q, e);
    endtask

    task automatic program_step(logic [STEP_W-1:0] v);
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        sb.step_ms = v;
    endtask

    function automatic logic [PERIOD_W-1:0] pick_period();
        int r;
        int span;
        r    = $urandom_range(0, 19);
        span = (sb.step_ms == 0) ? 40 : 3 * int'(sb.step_ms);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return PERIOD_W'($urandom());
        return PERIOD_W'($urandom_range(0, span));
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        int r;
        int pool[$];
        r = $urandom_range(0, 9);
        for (int i = 0; i < NT; i++)
        begin
            if (sb.armed[i])
                pool.push_back(i + 1);
        end
        if (r < 7 && pool.size() != 0)
            return HANDLE_W'(pool[$urandom_range(0, pool.size() - 1)]);
        if (r == 7)
            return '0;
        if (r == 8)
            return HANDLE_W'($urandom_range(1, NT));
        return HANDLE_W'($urandom_range(NT + 1, 31));
    endfunction

    task automatic run_mixed(int count);
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                issue_command(OP_SET, HANDLE_W'($urandom()), pick_period(),
                              QUEUE_W'($urandom()), $urandom());
            else if (r < 60)
                issue_command(OP_TICK, HANDLE_W'($urandom()), PERIOD_W'($urandom()),
                              QUEUE_W'($urandom()), $urandom());
            else if (r < 80)
                issue_command(OP_CANCEL, pick_handle(), PERIOD_W'($urandom()),
                              QUEUE_W'($urandom()), $urandom());
            else
                issue_command(OP_RESET, pick_handle(), pick_period(),
                              QUEUE_W'($urandom()), $urandom());
        end
    endtask

    // clear the table, fill every slot plus one, then fire all on one tick
    task automatic run_fill_and_drain();
        for (int i = 0; i < NT; i++)
        begin
            if (sb.armed[i])
                issue_command(OP_CANCEL, HANDLE_W'(i + 1), PERIOD_W'($urandom()),
                              QUEUE_W'($urandom()), $urandom());
        end
        issue_command(OP_TICK, '0, '0, '0, '0);
        repeat (NT + 1)
            issue_command(OP_SET, HANDLE_W'($urandom()),
                          PERIOD_W'($urandom_range(0, int'(sb.step_ms))),
                          QUEUE_W'($urandom()), $urandom());
        issue_command(OP_TICK, HANDLE_W'($urandom()), PERIOD_W'($urandom()),
                      QUEUE_W'($urandom()), $urandom());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_command(OP_SET, '0, '0, '0, '0);
        issue_command(OP_SET, '1, '1, '1, '1);
        issue_command(OP_SET, 5'd3, 31'd5, 16'h1234, 32'hA5A5_5A5A);
        issue_command(OP_CANCEL, '0, '0, '0, '0);
        issue_command(OP_RESET, '0, 31'd7, '0, '0);
        issue_command(OP_CANCEL, 5'd31, '0, '0, '0);
        issue_command(OP_RESET, 5'd17, 31'd7, '0, '0);
        issue_command(OP_CANCEL, 5'd4, '0, '0, '0);
        issue_command(OP_CANCEL, 5'd3, '0, '0, '0);
        issue_command(OP_CANCEL, 5'd3, '0, '0, '0);
        issue_command(OP_RESET, 5'd3, 31'd100, '0, '0);
        issue_command(OP_RESET, 5'd2, 31'd20, '0, '0);
        issue_command(OP_TICK, '0, '0, '0, '0);
        issue_command(OP_TICK, '1, '1, '1, '1);
        issue_command(OP_TICK, '0, '0, '0, '0);
        issue_command(OP_RESET, 5'd1, 31'd9, '0, '0);
        issue_command(OP_SET, 5'd16, 31'h4000_0000, 16'h8001, 32'h8000_0001);

        program_step(10'd1);
        run_mixed(15);
        program_step(10'd1000);
        run_mixed(15);
        program_step(10'd1023);
        run_fill_and_drain();
        run_mixed(10);
        program_step(10'd0);
        run_mixed(10);
        program_step(STEP_W'($urandom_range(1, 1000)));
        run_mixed(15);
        program_step(STEP_RESET);
        calm = 1'b1;
        run_mixed(15);

        in_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.err_count == 0)
            $display("** one_shot_timer_table_core: PASSED **");
        else
            $display("** one_shot_timer_table_core: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/otst_pkg.sv
rtl/otst_free_find.sv
rtl/one_shot_timer_table_core.sv
rtl/otst_checker.sv
verif/one_shot_timer_table_core_tb.sv
